// ===== rtl/cpa_pkg.sv =====
// Shared types, codes and constants of the chunk pool allocator.
package cpa_pkg;

  localparam int DEF_NUM_CHUNKS = 256;

  localparam int CNT_REG_W = 9;   // chunk_count register
  localparam int CB_W      = 13;  // chunk_bytes register
  localparam int ADDR_W    = 32;  // addresses and pool_base
  localparam int BCNT_W    = 20;  // byte_count field
  localparam int NEED_W    = 21;  // rounded chunk count of a byte count
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_REG_W-1:0] RST_CHUNK_COUNT = 9'd256;
  localparam logic [CB_W-1:0]      RST_CHUNK_BYTES = 13'd64;
  localparam logic [ADDR_W-1:0]    RST_POOL_BASE   = 32'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd2;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_WIPE_INIT,
    S_WIPE,
    S_IDLE,
    S_DIV_BYTES,
    S_WAIT_NEED,
    S_ALLOC_CHK,
    S_SCAN,
    S_FILL,
    S_MUL,
    S_ALLOC_FIN,
    S_RANGE,
    S_RANGE_CHK,
    S_WAIT_POS,
    S_FREE_SETUP
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    div_start;
    logic    div_sel_offset;
    logic    save_need;
    logic    save_pos;
    logic    range_calc;
    logic    scan_init;
    logic    scan_run;
    logic    fill_alloc;
    logic    fill_free;
    logic    fill_wipe;
    logic    fill_run;
    logic    mul;
    logic    finish;
    status_t res_status;
    logic    res_block;
    logic    res_owned;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic div_busy;
    logic need_ok;
    logic in_pool;
    logic scan_hit;
    logic scan_end;
    logic fill_done;
  } stat_t;

endpackage

// ===== rtl/chunk_pool_allocator.sv =====
// Top level of the chunk pool allocator: controller, datapath and checks.
//
//  channel   handshake               payload
//  request   start & !busy           req_type, byte_count, address
//  result    done (one-cycle strobe) status, block_address, owned
//  config    cfg_write               cfg_index, cfg_data
//
// Allocate runs a 32-step divide to round the byte count, a scan of one map bit
// per cycle, a fill that marks each chunk of the block, and a multiply for the
// block address. Free of an address in the pool runs two divides on the shared
// divider, then clears its chunks.
// After reset the map RAM is wiped one chunk per cycle, with busy high. The result
// is held on its outputs until the next result is written.
module chunk_pool_allocator
  import cpa_pkg::*;
#(
  parameter int NUM_CHUNKS = DEF_NUM_CHUNKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic [BCNT_W-1:0]     byte_count,
  input  logic [ADDR_W-1:0]     address,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [1:0]            status,
  output logic [ADDR_W-1:0]     block_address,
  output logic                  owned
);

  cmd_t  cmd;
  stat_t st;

  cpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  cpa_datapath #(
    .NUM_CHUNKS (NUM_CHUNKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .byte_count    (byte_count),
    .address       (address),
    .cmd           (cmd),
    .st            (st),
    .done          (done),
    .status        (status),
    .block_address (block_address),
    .owned         (owned)
  );

  a_alloc_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_ALLOC) |=> busy)
    else $error("allocate accepted without entering work");

  a_fail_has_no_block: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (block_address == '0) && !owned)
    else $error("failed item carries an address or ownership");

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result without a request");

  a_wipe_before_service: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("map taken into service before the wipe");

endmodule

// ===== rtl/cpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cpa_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient and remainder.
module cpa_div
  import cpa_pkg::*;
#(
  parameter int DW = ADDR_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DW-1:0]   dividend,
  input  logic [CB_W-1:0] divisor,
  output logic            busy,
  output logic [DW-1:0]   quotient,
  output logic [CB_W-1:0] remainder
);

  localparam int STEP_W = $clog2(DW + 1);

  logic [STEP_W-1:0] step;
  logic [CB_W:0]     shifted;
  logic              ge;
  logic [CB_W:0]     diff;

  assign shifted = {remainder, quotient[DW-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(DW);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[DW-2:0], ge};
      remainder <= ge ? diff[CB_W-1:0] : shifted[CB_W-1:0];
    end
  end

endmodule

// ===== rtl/cpa_datapath.sv =====
// Datapath: configuration, used-bit map, scan, fill, range check and results.
module cpa_datapath
  import cpa_pkg::*;
#(
  parameter int NUM_CHUNKS = DEF_NUM_CHUNKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            req_type,
  input  logic [BCNT_W-1:0]     byte_count,
  input  logic [ADDR_W-1:0]     address,
  input  cmd_t                  cmd,
  output stat_t                 st,
  output logic                  done,
  output logic [1:0]            status,
  output logic [ADDR_W-1:0]     block_address,
  output logic                  owned
);

  localparam int IDX_W  = $clog2(NUM_CHUNKS);
  localparam int CNT_W  = $clog2(NUM_CHUNKS + 1);
  localparam int CMP_W  = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
  localparam int SPAN_W = CNT_W + CB_W;
  localparam int RNG_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
  localparam int PROD_W = IDX_W + CB_W;

  // configuration
  logic [CNT_REG_W-1:0] chunk_count;
  logic [CB_W-1:0]      chunk_bytes;
  logic [ADDR_W-1:0]    pool_base;
  logic [CNT_W-1:0]     eff_count;
  logic [CB_W-1:0]      eff_bytes;

  // captured request
  req_t              req;
  logic [BCNT_W-1:0] bytes;
  logic [ADDR_W-1:0] addr;

  // division results
  logic [ADDR_W-1:0] div_q;
  logic [CB_W-1:0]   div_r;
  logic              div_busy;
  logic [NEED_W-1:0] need;
  logic [IDX_W-1:0]  pos;

  // range check
  logic [SPAN_W-1:0] span;
  logic [ADDR_W-1:0] offset;
  logic              below;
  logic              in_pool;

  // scan
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] ev_idx;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_next;
  logic             issue;
  logic             map_q;
  logic [CNT_W-1:0] start_calc;
  logic [IDX_W-1:0] start_idx;

  // fill
  logic [CNT_W-1:0]  fill_idx;
  logic [CNT_W-1:0]  fill_end;
  logic              fill_bit;
  logic              fill_we;
  logic [NEED_W-1:0] room;

  logic [PROD_W-1:0] product;
  status_t           status_reg;

  always_comb begin
    if (CMP_W'(chunk_count) > CMP_W'(NUM_CHUNKS)) begin
      eff_count = CNT_W'(NUM_CHUNKS);
    end else begin
      eff_count = CNT_W'(chunk_count);
    end
  end

  assign eff_bytes = (chunk_bytes == '0) ? CB_W'(1) : chunk_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= RST_CHUNK_COUNT;
      chunk_bytes <= RST_CHUNK_BYTES;
      pool_base   <= RST_POOL_BASE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CHUNK_COUNT: chunk_count <= cfg_data[CNT_REG_W-1:0];
        CFG_CHUNK_BYTES: chunk_bytes <= cfg_data[CB_W-1:0];
        CFG_POOL_BASE:   pool_base   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req   <= req_t'(req_type);
      bytes <= byte_count;
      addr  <= address;
    end
  end

  cpa_div #(
    .DW (ADDR_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (cmd.div_sel_offset ? offset : ADDR_W'(bytes)),
    .divisor   (eff_bytes),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (cmd.save_need) begin
      need <= div_q[NEED_W-1:0] + NEED_W'(div_r != '0);
    end
    if (cmd.save_pos) begin
      pos <= div_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.range_calc) begin
      span   <= SPAN_W'(eff_count) * SPAN_W'(eff_bytes);
      offset <= addr - pool_base;
      below  <= addr < pool_base;
    end
  end

  assign in_pool = !below && (RNG_W'(offset) < RNG_W'(span));

  // Scan: read one map bit per cycle, evaluate it the cycle after.
  assign issue      = rd_cnt < eff_count;
  assign run_next   = map_q ? '0 : run + 1'b1;
  assign start_calc = CNT_W'(ev_idx) + CNT_W'(1) - CNT_W'(need);
  assign start_idx  = start_calc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      rd_cnt  <= '0;
      rd_pend <= 1'b0;
      run     <= '0;
    end else if (cmd.scan_run) begin
      rd_cnt  <= rd_cnt + CNT_W'(issue);
      rd_pend <= issue;
      ev_idx  <= rd_cnt[IDX_W-1:0];
      if (rd_pend) begin
        run <= run_next;
      end
    end
  end

  // Fill: write one map bit per cycle over [fill_idx, fill_end).
  assign fill_we = cmd.fill_run && (fill_idx < fill_end);
  assign room    = NEED_W'(eff_count - CNT_W'(pos));

  always_ff @(posedge clk) begin
    if (cmd.fill_wipe) begin
      fill_idx <= '0;
      fill_end <= CNT_W'(NUM_CHUNKS);
      fill_bit <= 1'b0;
    end else if (cmd.fill_alloc) begin
      fill_idx <= start_calc;
      fill_end <= CNT_W'(ev_idx) + CNT_W'(1);
      fill_bit <= 1'b1;
    end else if (cmd.fill_free) begin
      fill_idx <= CNT_W'(pos);
      fill_end <= (need > room) ? eff_count : CNT_W'(NEED_W'(pos) + need);
      fill_bit <= 1'b0;
    end else if (fill_we) begin
      fill_idx <= fill_idx + 1'b1;
    end
  end

  cpa_ram #(
    .WIDTH (1),
    .DEPTH (NUM_CHUNKS)
  ) u_map (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_idx[IDX_W-1:0]),
    .wdata (fill_bit),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (map_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.fill_alloc) begin
      product <= PROD_W'(start_idx) * PROD_W'(eff_bytes);
    end else if (cmd.mul) begin
      product <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_reg    <= cmd.res_status;
      block_address <= cmd.res_block ? pool_base + ADDR_W'(product) : '0;
      owned         <= cmd.res_owned && in_pool;
    end
  end

  assign status = status_reg;

  always_comb begin
    st           = '0;
    st.req       = req;
    st.div_busy  = div_busy;
    st.need_ok   = (need != '0) && (need <= NEED_W'(eff_count));
    st.in_pool   = in_pool;
    st.scan_hit  = rd_pend && (NEED_W'(run_next) == need);
    st.scan_end  = !issue && !rd_pend;
    st.fill_done = fill_idx >= fill_end;
  end

endmodule

// ===== rtl/cpa_ctrl.sv =====
// Controller: sequences wipe, allocate, free and query over the datapath.
module cpa_ctrl
  import cpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  stat_t      st,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_WIPE_INIT: begin
        cmd.fill_wipe = 1'b1;
        state_next    = S_WIPE;
      end
      S_WIPE: begin
        cmd.fill_run = 1'b1;
        if (st.fill_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          case (req_t'(req_type))
            REQ_ALLOC: state_next = S_DIV_BYTES;
            REQ_FREE:  state_next = S_RANGE;
            REQ_QUERY: state_next = S_RANGE;
            default: begin
              cmd.finish     = 1'b1;
              cmd.res_status = ST_OK;
            end
          endcase
        end
      end
      S_DIV_BYTES: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_NEED;
      end
      S_WAIT_NEED: begin
        if (!st.div_busy) begin
          cmd.save_need = 1'b1;
          state_next    = (st.req == REQ_ALLOC) ? S_ALLOC_CHK : S_FREE_SETUP;
        end
      end
      S_ALLOC_CHK: begin
        if (st.need_ok) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_NO_SPACE;
          state_next     = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_hit) begin
          cmd.fill_alloc = 1'b1;
          state_next     = S_FILL;
        end else if (st.scan_end) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_NO_SPACE;
          state_next     = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.fill_run = 1'b1;
        if (st.fill_done) begin
          if (st.req == REQ_ALLOC) begin
            state_next = S_MUL;
          end else begin
            cmd.finish     = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_IDLE;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ALLOC_FIN;
      end
      S_ALLOC_FIN: begin
        cmd.finish     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_block  = 1'b1;
        state_next     = S_IDLE;
      end
      S_RANGE: begin
        cmd.range_calc = 1'b1;
        state_next     = S_RANGE_CHK;
      end
      S_RANGE_CHK: begin
        if (st.req == REQ_QUERY) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_owned  = 1'b1;
          state_next     = S_IDLE;
        end else if (!st.in_pool) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_OUTSIDE;
          state_next     = S_IDLE;
        end else begin
          cmd.div_start      = 1'b1;
          cmd.div_sel_offset = 1'b1;
          state_next         = S_WAIT_POS;
        end
      end
      S_WAIT_POS: begin
        // hold the offset select until the quotient is taken
        cmd.div_sel_offset = 1'b1;
        if (!st.div_busy) begin
          cmd.save_pos = 1'b1;
          state_next   = S_DIV_BYTES;
        end
      end
      S_FREE_SETUP: begin
        cmd.fill_free = 1'b1;
        state_next    = S_FILL;
      end
      default: begin
        state_next = S_WIPE_INIT;
      end
    endcase
  end

endmodule

// ===== test/chunk_pool_allocator_tb.sv =====
// Self-checking testbench for the chunk pool allocator: directed and random requests.
`timescale 1ns / 1ps

import cpa_pkg::*;

typedef struct packed {
  status_t             status;
  logic [ADDR_W-1:0]   block;
  logic                owned;
} pool_reply_t;

// Tracks the used-chunk map and register state, and holds the replies still owed.
class pool_tracker;
  bit [DEF_NUM_CHUNKS-1:0] chunk_used;
  logic [CNT_REG_W-1:0]    count_reg;
  logic [CB_W-1:0]         size_reg;
  logic [ADDR_W-1:0]       base_reg;
  pool_reply_t             owed_replies[$];
  int                      errors;
  int                      checked;

  function new();
    chunk_used = '0;
    count_reg  = RST_CHUNK_COUNT;
    size_reg   = RST_CHUNK_BYTES;
    base_reg   = RST_POOL_BASE;
    errors     = 0;
    checked    = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CHUNK_COUNT: count_reg = data[CNT_REG_W-1:0];
      CFG_CHUNK_BYTES: size_reg = data[CB_W-1:0];
      CFG_POOL_BASE:   base_reg = data[ADDR_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned chunks();
    return (count_reg > DEF_NUM_CHUNKS) ? DEF_NUM_CHUNKS : count_reg;
  endfunction

  function int unsigned chunk_size();
    return (size_reg == 0) ? 1 : size_reg;
  endfunction

  function longint unsigned span();
    return longint'(chunks()) * longint'(chunk_size());
  endfunction

  // End bound is exclusive and formed without wrap.
  function bit owns(logic [ADDR_W-1:0] addr);
    if (addr < base_reg) return 1'b0;
    return {32'd0, addr - base_reg} < span();
  endfunction

  function int unsigned round_chunks(logic [BCNT_W-1:0] nbytes);
    return nbytes / chunk_size() + (((nbytes % chunk_size()) != 0) ? 1 : 0);
  endfunction

  function pool_reply_t predict_reply(req_t kind, logic [BCNT_W-1:0] nbytes,
                                      logic [ADDR_W-1:0] addr);
    pool_reply_t r;
    int unsigned cnt, need, run, first, pos, stop, i;
    bit found;
    r.status = ST_OK;
    r.block  = '0;
    r.owned  = 1'b0;
    cnt = chunks();
    case (kind)
      REQ_ALLOC: begin
        need  = round_chunks(nbytes);
        run   = 0;
        first = 0;
        found = 1'b0;
        if (need != 0 && need <= cnt) begin
          for (i = 0; i < cnt && !found; i++) begin
            run = chunk_used[i] ? 0 : run + 1;
            if (run == need) begin
              first = i + 1 - need;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          for (i = first; i < first + need; i++) chunk_used[i] = 1'b1;
          r.block = base_reg + 32'(first * chunk_size());
        end else begin
          r.status = ST_NO_SPACE;
        end
      end
      REQ_FREE: begin
        if (!owns(addr)) begin
          r.status = ST_OUTSIDE;
        end else begin
          pos  = (addr - base_reg) / chunk_size();
          need = round_chunks(nbytes);
          // clamp the release at the pool end
          stop = (need > cnt - pos) ? cnt : pos + need;
          for (i = pos; i < stop; i++) chunk_used[i] = 1'b0;
        end
      end
      REQ_QUERY: r.owned = owns(addr);
      default: ;
    endcase
    return r;
  endfunction

  function void note_request(req_t kind, logic [BCNT_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
    owed_replies.push_back(predict_reply(kind, nbytes, addr));
  endfunction

  function void check_reply(logic [1:0] st, logic [ADDR_W-1:0] blk, logic ow);
    pool_reply_t want;
    checked++;
    if (owed_replies.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("reply %0d with no request outstanding: status %0d block %h owned %b",
                 checked, st, blk, ow);
      return;
    end
    want = owed_replies.pop_front();
    if (st !== want.status || blk !== want.block || ow !== want.owned) begin
      errors++;
      if (errors <= 10)
        $display({"reply %0d mismatch: expected status %0d block %h owned %b, ",
                  "got status %0d block %h owned %b"},
                 checked, want.status, want.block, want.owned, st, blk, ow);
    end
  endfunction
endclass

module chunk_pool_allocator_tb;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 64;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            req_type = '0;
  logic [BCNT_W-1:0]     byte_count = '0;
  logic [ADDR_W-1:0]     address = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [1:0]            status;
  logic [ADDR_W-1:0]     block_address;
  logic                  owned;

  pool_tracker tracker = new();
  int quiet_cycles = 0;

  chunk_pool_allocator uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .byte_count(byte_count),
    .address(address),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .block_address(block_address),
    .owned(owned)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check replies and watch for a stuck block.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) tracker.check_reply(status, block_address, owned);
      if ((start && busy === 1'b0) || done === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("chunk_pool_allocator_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic issue(req_t kind, logic [BCNT_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
    start      <= 1'b1;
    req_type   <= kind;
    byte_count <= nbytes;
    address    <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(kind, nbytes, addr);
  endtask

  // Hold start low for a random stretch, or keep it high for back-to-back items.
  task automatic pause(bit steady);
    int n, r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] cnt, logic [CFG_DATA_W-1:0] cb,
                           logic [CFG_DATA_W-1:0] base);
    start <= 1'b0;
    while (tracker.owed_replies.size() != 0 || busy !== 1'b0) @(posedge clk);
    write_cfg(CFG_CHUNK_COUNT, cnt);
    write_cfg(CFG_CHUNK_BYTES, cb);
    write_cfg(CFG_UNUSED, $urandom());
    write_cfg(CFG_POOL_BASE, base);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned cnt, cb, r;
    logic [ADDR_W-1:0] base, top;
    cnt  = tracker.chunks();
    cb   = tracker.chunk_size();
    base = tracker.base_reg;
    top  = base + 32'(tracker.span());
    r    = $urandom_range(0, 99);
    if (cnt != 0 && r < 70)
      return base + 32'($urandom_range(0, cnt - 1) * cb) +
             (($urandom_range(0, 3) == 0) ? $urandom_range(0, cb - 1) : 0);
    else if (r < 78) return base - 1;
    else if (r < 86) return top;
    else if (r < 94) return top - 1;
    return $urandom();
  endfunction

  // Byte count of a few whole or partial chunks.
  function automatic logic [BCNT_W-1:0] few_chunks_bytes();
    int unsigned cb;
    cb = tracker.chunk_size();
    return BCNT_W'($urandom_range(0, 3) * cb + $urandom_range(1, cb));
  endfunction

  task automatic random_item();
    int unsigned r, s;
    logic [BCNT_W-1:0] nbytes;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < 45) begin
      if (s < 8) nbytes = '0;
      else if (s < 16) nbytes = BCNT_W'($urandom());
      else if (s < 22) nbytes = BCNT_W'(tracker.span());
      else nbytes = few_chunks_bytes();
      issue(REQ_ALLOC, nbytes, $urandom());
    end else if (r < 75) begin
      if (s < 10) nbytes = '0;
      else if (s < 20) nbytes = '1;
      else if (s < 28) nbytes = BCNT_W'($urandom());
      else nbytes = few_chunks_bytes();
      issue(REQ_FREE, nbytes, pick_address());
    end else if (r < 95) begin
      issue(REQ_QUERY, BCNT_W'($urandom()), pick_address());
    end else begin
      issue(REQ_NONE, BCNT_W'($urandom()), $urandom());
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] cnt, logic [CFG_DATA_W-1:0] cb,
                           logic [CFG_DATA_W-1:0] base, int n);
    bit steady;
    configure(cnt, cb, base);
    steady = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      random_item();
      pause(steady);
    end
  endtask

  initial begin
    int unsigned r;
    logic [CFG_DATA_W-1:0] cnt, cb;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 256 chunks of 64 bytes at address 0.
    configure(CFG_DATA_W'(RST_CHUNK_COUNT), CFG_DATA_W'(RST_CHUNK_BYTES), RST_POOL_BASE);
    issue(REQ_ALLOC, 20'd0, 32'd0);       pause(1'b0);
    issue(REQ_ALLOC, 20'd1, '1);          pause(1'b0);
    issue(REQ_ALLOC, 20'd64, 32'd0);      pause(1'b0);
    issue(REQ_ALLOC, 20'd65, 32'd0);      pause(1'b0);
    issue(REQ_ALLOC, '1, 32'd0);          pause(1'b0);
    issue(REQ_ALLOC, 20'd16384, 32'd0);   pause(1'b0);
    issue(REQ_QUERY, 20'd0, 32'd0);       pause(1'b0);
    issue(REQ_QUERY, '1, 32'd16383);      pause(1'b0);
    issue(REQ_QUERY, 20'd0, 32'd16384);   pause(1'b0);
    issue(REQ_QUERY, 20'd0, '1);          pause(1'b0);
    issue(REQ_FREE, 20'd0, 32'd64);       pause(1'b0);
    issue(REQ_FREE, 20'd64, 32'd16384);   pause(1'b0);
    issue(REQ_FREE, '1, '1);              pause(1'b0);
    issue(REQ_ALLOC, 20'd16128, 32'd0);   pause(1'b0);
    issue(REQ_ALLOC, 20'd1, 32'd0);       pause(1'b0);
    issue(REQ_FREE, '1, 32'd133);         pause(1'b0);
    issue(REQ_NONE, '1, '1);              pause(1'b0);
    issue(REQ_ALLOC, 20'd16256, 32'd0);   pause(1'b0);
    issue(REQ_FREE, '1, 32'd0);           pause(1'b0);
    issue(REQ_ALLOC, 20'd16384, 32'd0);   pause(1'b0);
    issue(REQ_FREE, 20'd16384, 32'd16383); pause(1'b0);
    issue(REQ_FREE, 20'd16384, 32'd0);    pause(1'b0);

    // Extreme settings: one-byte pool at the top of memory, wrapping addresses,
    // empty pool, saturated count with zero chunk size, oversized chunks.
    run_phase(32'd1, 32'd1, 32'hFFFF_FFFF, 40);
    run_phase(32'd256, 32'd4096, 32'hFFFF_F000, 50);
    run_phase(32'd0, 32'd64, 32'h0000_1000, 20);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_E000, $urandom(), 40);
    run_phase(32'd8, 32'h1FFF, $urandom(), 40);

    repeat (8) begin
      r = $urandom_range(0, 99);
      if (r < 75) cnt = $urandom_range(1, 32);
      else if (r < 90) cnt = 32'd256;
      else cnt = $urandom();
      r = $urandom_range(0, 99);
      if (r < 60) cb = $urandom_range(1, 128);
      else if (r < 80) cb = $urandom_range(1, 4096);
      else if (r < 90) cb = '0;
      else cb = $urandom();
      run_phase(cnt, cb, $urandom(), 45);
    end

    start <= 1'b0;
    while (tracker.owed_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("chunk_pool_allocator_tb passed");
    end else begin
      $display("chunk_pool_allocator_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cpa_pkg.sv
rtl/cpa_ram.sv
rtl/cpa_div.sv
rtl/cpa_datapath.sv
rtl/cpa_ctrl.sv
rtl/chunk_pool_allocator.sv
test/chunk_pool_allocator_tb.sv
